/* rtl/stepper_angle_tracking_controller_top_defines.svh */
// ---------------------------------------------------------------------------
// Stepper angle tracking controller assertion macros
// Concurrent property checks for the top level; empty when NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef STEPPER_ANGLE_TRACKING_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_ANGLE_TRACKING_CONTROLLER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SATC_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("satc: same-cycle property violated");
`define SATC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("satc: next-cycle property violated");
`else
`define SATC_ASSERT_SAME(name, clk, rst, ante, cons)
`define SATC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/satc_pkg.sv */
// ---------------------------------------------------------------------------
// Stepper angle tracking controller package
// Shared widths, register codes, state encodings and payload structs.
// ---------------------------------------------------------------------------
`default_nettype none

package satc_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int CPR_W      = 13;
  localparam int SPEED_W    = 8;
  localparam int SCALE_W    = 20;
  localparam int ERR_W      = CPR_W + 2;
  localparam int DIV_CNT_W  = $clog2(SCALE_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [CPR_W-1:0]   CPR_RESET     = 13'd960;
  localparam logic [SPEED_W-1:0] LIMIT_RESET   = 8'd100;
  localparam logic [SPEED_W-1:0] HOMING_RESET  = 8'd10;
  localparam logic [SCALE_W-1:0] SCALE_RESET   = 20'd200000;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(SCALE_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNTS_PER_REV    = 2'd0,
    CFG_SPEED_LIMIT       = 2'd1,
    CFG_HOMING_SPEED      = 2'd2,
    CFG_HALF_PERIOD_SCALE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_LEAVE = 2'd0,
    PH_SEEK  = 2'd1,
    PH_TRACK = 2'd2
  } ctrl_phase_t;

  typedef enum logic [1:0] {
    PU_IDLE = 2'd0,
    PU_LOW  = 2'd1,
    PU_HIGH = 2'd2
  } pulse_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SAMPLE,
    ST_CLAMP,
    ST_DIV,
    ST_LOAD,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic                  req_type;
    logic [ANGLE_BITS-1:0] target_angle;
    logic [ANGLE_BITS-1:0] actual_angle;
    logic                  light_barrier;
  } req_t;

  typedef struct packed {
    logic               step_level;
    logic               direction;
    logic [SPEED_W-1:0] speed_now;
    logic               homed;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic sample;
    logic clamp;
    logic div_start;
    logic div_step;
    logic period_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic start_period;
    logic tracking;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/satc_ctrl.sv */
// ---------------------------------------------------------------------------
// Stepper angle tracking controller sequencer
// Handshake control and step sequencing for one item at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module satc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_type,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output satc_pkg::dp_cmd_t    cmd,
  input  satc_pkg::dp_status_t status
);
  import satc_pkg::*;

  seq_state_t state, state_next;
  logic       out_free;

  assign req_stall = rst || (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = req_type ? ST_SAMPLE : ST_TICK;
        end
      end
      ST_TICK: begin
        cmd.tick = 1'b1;
        if (status.start_period) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SAMPLE: begin
        cmd.sample = 1'b1;
        state_next = status.tracking ? ST_CLAMP : ST_OUT;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_OUT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.period_load = 1'b1;
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/satc_datapath.sv */
// ---------------------------------------------------------------------------
// Stepper angle tracking controller datapath
// Registers, homing and error logic, step timer and serial divider.
// ---------------------------------------------------------------------------
`default_nettype none

module satc_datapath #(
  parameter int TIMER_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [satc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [satc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  satc_pkg::req_t                      req,
  output satc_pkg::rsp_t                      rsp,
  input  satc_pkg::dp_cmd_t                   cmd,
  output satc_pkg::dp_status_t                status
);
  import satc_pkg::*;

  logic [CPR_W-1:0]   counts_per_rev;
  logic [SPEED_W-1:0] speed_limit;
  logic [SPEED_W-1:0] homing_speed;
  logic [SCALE_W-1:0] half_period_scale;

  ctrl_phase_t        control_phase;
  logic [SPEED_W-1:0] track_speed;
  logic               dir_level;
  pulse_phase_t       pulse_phase;
  logic               pulse_line;
  logic [TIMER_BITS-1:0] half_count;
  logic [TIMER_BITS-1:0] half_length;

  req_t               req_q;
  logic signed [ERR_W-1:0] err_mag;
  logic               err_dir;
  logic signed [ERR_W-1:0] err_mag_next;
  logic               err_dir_next;

  logic [SPEED_W-1:0] div_rem;
  logic [SCALE_W-1:0] div_q;
  logic [SPEED_W-1:0] div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SPEED_W:0]   rem_sh;
  logic [SPEED_W:0]   rem_diff;

  logic [SPEED_W-1:0] speed_eff;
  logic               expired;
  logic               need_period;
  logic [TIMER_BITS-1:0] quot_sat;
  logic [TIMER_BITS-1:0] half_new;

  logic signed [ERR_W-1:0] diff;
  logic signed [ERR_W-1:0] cpr_s;
  logic signed [ERR_W-1:0] thr_s;
  logic signed [ERR_W-1:0] limit_s;
  logic [SPEED_W-1:0] clamped;

  assign speed_eff   = (control_phase == PH_TRACK) ? track_speed : homing_speed;
  assign expired     = half_count >= half_length;
  assign need_period = (pulse_phase == PU_IDLE) || ((pulse_phase == PU_HIGH) && expired);

  assign status.start_period = need_period && (speed_eff != '0);
  assign status.tracking     = control_phase == PH_TRACK;
  assign status.div_last     = div_cnt == DIV_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev    <= CPR_RESET;
      speed_limit       <= LIMIT_RESET;
      homing_speed      <= HOMING_RESET;
      half_period_scale <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COUNTS_PER_REV:    counts_per_rev    <= cfg_data[CPR_W-1:0];
        CFG_SPEED_LIMIT:       speed_limit       <= cfg_data[SPEED_W-1:0];
        CFG_HOMING_SPEED:      homing_speed      <= cfg_data[SPEED_W-1:0];
        CFG_HALF_PERIOD_SCALE: half_period_scale <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  always_comb begin
    diff    = $signed({{(ERR_W-ANGLE_BITS){1'b0}}, req_q.target_angle})
            - $signed({{(ERR_W-ANGLE_BITS){1'b0}}, req_q.actual_angle});
    cpr_s   = $signed({{(ERR_W-CPR_W){1'b0}}, counts_per_rev});
    thr_s   = $signed({{(ERR_W-CPR_W+1){1'b0}}, counts_per_rev[CPR_W-1:1]});
    limit_s = $signed({{(ERR_W-SPEED_W){1'b0}}, speed_limit});
    if (diff > thr_s) begin
      err_dir_next = 1'b0;
      err_mag_next = cpr_s - diff;
    end else if (diff < -thr_s) begin
      err_dir_next = 1'b1;
      err_mag_next = cpr_s + diff;
    end else if (diff >= 0) begin
      err_dir_next = 1'b1;
      err_mag_next = diff;
    end else begin
      err_dir_next = 1'b0;
      err_mag_next = -diff;
    end
  end

  always_comb begin
    if (err_mag < 0) begin
      clamped = '0;
    end else if (err_mag > limit_s) begin
      clamped = speed_limit;
    end else begin
      clamped = err_mag[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      err_mag <= err_mag_next;
      err_dir <= err_dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_phase <= PH_LEAVE;
      track_speed   <= '0;
      dir_level     <= 1'b0;
    end else if (cmd.sample) begin
      unique case (control_phase)
        PH_LEAVE: begin
          if (!req_q.light_barrier) begin
            control_phase <= PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (req_q.light_barrier) begin
            control_phase <= PH_TRACK;
            track_speed   <= '0;
            dir_level     <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.clamp) begin
      dir_level   <= err_dir;
      track_speed <= clamped;
    end
  end

  assign rem_sh   = {div_rem, div_q[SCALE_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_q   <= half_period_scale;
      div_den <= speed_eff;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, div_den}) begin
        div_rem <= rem_diff[SPEED_W-1:0];
        div_q   <= {div_q[SCALE_W-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh[SPEED_W-1:0];
        div_q   <= {div_q[SCALE_W-2:0], 1'b0};
      end
    end
  end

  if (TIMER_BITS >= SCALE_W) begin : g_wide_timer
    assign quot_sat = TIMER_BITS'(div_q);
  end else begin : g_narrow_timer
    assign quot_sat = (|div_q[SCALE_W-1:TIMER_BITS]) ? '1 : div_q[TIMER_BITS-1:0];
  end

  assign half_new = (quot_sat == '0) ? TIMER_BITS'(1) : quot_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_phase <= PU_IDLE;
      pulse_line  <= 1'b0;
      half_count  <= '0;
      half_length <= '0;
    end else if (cmd.period_load) begin
      half_length <= half_new;
      half_count  <= TIMER_BITS'(1);
      pulse_line  <= 1'b0;
      pulse_phase <= PU_LOW;
    end else if (cmd.tick) begin
      if (need_period) begin
        if (speed_eff == '0) begin
          pulse_phase <= PU_IDLE;
        end
      end else if ((pulse_phase == PU_LOW) && expired) begin
        pulse_line  <= 1'b1;
        pulse_phase <= PU_HIGH;
        half_count  <= TIMER_BITS'(1);
      end else begin
        half_count <= half_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.step_level <= pulse_line;
      rsp.direction  <= dir_level;
      rsp.speed_now  <= speed_eff;
      rsp.homed      <= control_phase == PH_TRACK;
    end
  end

endmodule

`default_nettype wire

/* rtl/stepper_angle_tracking_controller_top.sv */
// ---------------------------------------------------------------------------
// Stepper angle tracking controller
// Homing, angle tracking and step pulse generation for one stepper axis.
// ---------------------------------------------------------------------------
// Request channel (req_valid, req_stall, req) carries ticks and samples;
// response channel (rsp_valid, rsp_stall, rsp) returns one item per request.
// Configuration registers are written by the user through cfg_we, cfg_index,
// cfg_data only while no request is in flight; the block does not enforce it.
// Sequencer states from accept to response:
//   sample before tracking, or tick inside a half period: SAMPLE or TICK, OUT
//   sample while tracking: SAMPLE, CLAMP, OUT
//   tick that starts a step period: TICK, DIV, LOAD, OUT
// One request is in flight at a time. A tick that starts a step period runs
// the restoring divider, one quotient bit per cycle over the 20-bit half
// period scale.
// A finished response sits in an output register, so the sequencer returns
// to accept the next request while rsp_stall is high, and holds the
// following response until the register is taken.
// Reset (rst, synchronous) loads register defaults, restarts homing and
// idles the step line low; req_stall is high during reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stepper_angle_tracking_controller_top_defines.svh"

module stepper_angle_tracking_controller_top #(
  parameter int TIMER_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  satc_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output satc_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [satc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [satc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import satc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  satc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

  satc_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .cmd       (cmd),
    .status    (status)
  );

  `SATC_ASSERT_NEXT(a_busy_after_transfer, clk, rst, req_valid && !req_stall, req_stall)
  `SATC_ASSERT_NEXT(a_homed_sticky, clk, rst, rsp_valid && rsp.homed, !rsp_valid || rsp.homed)
  `SATC_ASSERT_NEXT(a_div_runs, clk, rst, cmd.div_start, cmd.div_step)
  `SATC_ASSERT_SAME(a_load_idle_timer, clk, rst, cmd.period_load, !cmd.tick && !cmd.sample)

endmodule

`default_nettype wire
